// File: rtl/core/assert_macros.svh
// Assertion macros shared by the hasher RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define DFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define DFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dfh_pkg.sv
// Package for the dual-lane FNV-1a hasher: transaction types, actions, constants.
// No dependencies.
package dfh_pkg;

  // Lane and byte geometry
  localparam int LaneBits    = 64;
  localparam int WordBits    = 64;
  localparam int WordBytes   = 8;     // bytes absorbed per word action, 1..8
  localparam int ByteCntW    = $clog2(WordBytes + 1);
  localparam int DigestChars = 32;
  localparam int CharIdxW    = $clog2(DigestChars);

  // FNV-64 prime 0x100000001b3 = 2^40 + 0x1b3
  localparam int               PrimeShift = 40;
  localparam logic [8:0]       PrimeLow   = 9'h1b3;

  // Lane seeds
  localparam logic [63:0] HighSeed = 64'd14695981039346656037;
  localparam logic [63:0] LowSeed  = 64'd7809847782465536322;

  // Actions
  localparam logic [1:0] ActRestart = 2'd0;
  localparam logic [1:0] ActByte    = 2'd1;
  localparam logic [1:0] ActWord    = 2'd2;
  localparam logic [1:0] ActEmit    = 2'd3;

  // Lowercase hex ASCII
  localparam logic [6:0] HexDigits [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  byte_value;
    logic [63:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0] hex_char;
    logic       last_char;
  } out_item_t;

  // Sequencer to output stage: one digest nibble
  typedef struct packed {
    logic       vld;
    logic [3:0] nibble;
    logic       last;
  } emit_req_t;

endpackage

// File: rtl/core/dfh_fnv_step.sv
// Shared FNV-1a round: xor one byte into a lane, multiply by the 64-bit prime.
// Depends on dfh_pkg.
module dfh_fnv_step
  import dfh_pkg::*;
(
  input  logic [LaneBits-1:0] lane_in,
  input  logic [7:0]          byte_in,
  output logic [LaneBits-1:0] lane_out
);

  logic [LaneBits-1:0] mixed;
  logic [LaneBits-1:0] prod_low;

  // prime = 2^40 + 0x1b3, so the product is a shift plus a narrow multiply
  assign mixed    = lane_in ^ {{(LaneBits-8){1'b0}}, byte_in};
  assign prod_low = mixed * {{(LaneBits-9){1'b0}}, PrimeLow};
  assign lane_out = (mixed << PrimeShift) + prod_low;

endmodule

// File: rtl/core/dfh_emit.sv
// Output register: turns a digest nibble into an ASCII hex character.
// Depends on dfh_pkg.
module dfh_emit
  import dfh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  emit_req_t req,
  output logic      take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;

  // register is free when empty or being drained this cycle
  assign take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.vld) begin
      out_data_r.hex_char  <= HexDigits[req.nibble];
      out_data_r.last_char <= req.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/dual_fnv1a_symbol_hasher.sv
// Dual-lane FNV-1a hasher top level: sequencer, lane registers, shared round unit.
// Depends on dfh_pkg, dfh_fnv_step, dfh_emit and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_item_t (action, byte, word)
//   out_    | output    | out_valid/out_stall | out_item_t (hex char, last)
//
// One round unit serves both lanes: each byte goes through it for the high lane, then the low lane.
// Restart loads both lane seeds; byte and word actions absorb their bytes one after another.
// Emit sends one character per cycle into the output register, unless out_stall holds it,
// DigestChars characters in all; in_stall is high until the last one is issued.
// Synchronous reset loads both lane seeds and empties the output register.
`include "assert_macros.svh"
module dual_fnv1a_symbol_hasher
  import dfh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StAbsorb = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0]          state_r,    state_nxt;
  logic [LaneBits-1:0] hi_r,       hi_nxt;
  logic [LaneBits-1:0] lo_r,       lo_nxt;
  logic                lane_sel_r, lane_sel_nxt;
  logic [WordBits-1:0] data_r,     data_nxt;
  logic [ByteCntW-1:0] byte_idx_r, byte_idx_nxt;
  logic [ByteCntW-1:0] nbytes_r,   nbytes_nxt;
  logic [CharIdxW-1:0] char_idx_r, char_idx_nxt;

  logic                in_acc;
  logic [LaneBits-1:0] cur_lane;
  logic [LaneBits-1:0] step_out;
  logic [LaneBits-1:0] emit_lane;
  logic                char_last;
  emit_req_t           req;
  logic                take;
  logic                hex_ok;

  assign in_stall = (state_r != StIdle);
  assign in_acc   = in_valid && !in_stall;

  // Shared round unit, lane chosen by the sequencer
  assign cur_lane = lane_sel_r ? lo_r : hi_r;

  dfh_fnv_step u_step (
    .lane_in  (cur_lane),
    .byte_in  (data_r[7:0]),
    .lane_out (step_out)
  );

  // Digest nibble pick: high lane first, most significant nibble first
  assign emit_lane  = char_idx_r[CharIdxW-1] ? lo_r : hi_r;
  assign char_last  = (char_idx_r == CharIdxW'(DigestChars - 1));
  assign req.vld    = (state_r == StEmit);
  assign req.nibble = emit_lane[{~char_idx_r[3:0], 2'b00} +: 4];
  assign req.last   = char_last;

  dfh_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    lane_sel_nxt = lane_sel_r;
    data_nxt     = data_r;
    byte_idx_nxt = byte_idx_r;
    nbytes_nxt   = nbytes_r;
    char_idx_nxt = char_idx_r;
    unique case (state_r)
      StIdle: begin
        if (in_acc) begin
          unique case (in_data.action)
            ActRestart: begin
              hi_nxt = HighSeed;
              lo_nxt = LowSeed;
            end
            ActByte: begin
              data_nxt     = {{(WordBits-8){1'b0}}, in_data.byte_value};
              nbytes_nxt   = ByteCntW'(1);
              byte_idx_nxt = '0;
              lane_sel_nxt = 1'b0;
              state_nxt    = StAbsorb;
            end
            ActWord: begin
              // all eight bytes are absorbed, least significant byte first
              data_nxt     = in_data.word_value;
              nbytes_nxt   = ByteCntW'(WordBytes);
              byte_idx_nxt = '0;
              lane_sel_nxt = 1'b0;
              state_nxt    = StAbsorb;
            end
            ActEmit: begin
              char_idx_nxt = '0;
              state_nxt    = StEmit;
            end
            default: ;
          endcase
        end
      end
      StAbsorb: begin
        if (!lane_sel_r) begin
          hi_nxt       = step_out;
          lane_sel_nxt = 1'b1;
        end else begin
          lo_nxt       = step_out;
          lane_sel_nxt = 1'b0;
          data_nxt     = data_r >> 8;
          byte_idx_nxt = byte_idx_r + ByteCntW'(1);
          if (byte_idx_r == nbytes_r - ByteCntW'(1)) begin
            state_nxt = StIdle;
          end
        end
      end
      StEmit: begin
        if (take) begin
          char_idx_nxt = char_idx_r + CharIdxW'(1);
          if (char_last) begin
            state_nxt = StIdle;
          end
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  // Control and lane state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= StIdle;
      hi_r       <= HighSeed;
      lo_r       <= LowSeed;
      lane_sel_r <= 1'b0;
      byte_idx_r <= '0;
      nbytes_r   <= '0;
      char_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      hi_r       <= hi_nxt;
      lo_r       <= lo_nxt;
      lane_sel_r <= lane_sel_nxt;
      byte_idx_r <= byte_idx_nxt;
      nbytes_r   <= nbytes_nxt;
      char_idx_r <= char_idx_nxt;
    end
  end

  // Byte shift register, payload only
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Checks
  assign hex_ok = (out_data.hex_char >= 7'd48 && out_data.hex_char <= 7'd57) ||
                  (out_data.hex_char >= 7'd97 && out_data.hex_char <= 7'd102);

  `DFH_ASSERT(a_hex_range, out_valid |-> hex_ok, "digest character is not lowercase hex")
  `DFH_ASSERT(a_emit_keeps_lanes, (state_r == StEmit) |=> $stable({hi_r, lo_r}), "lanes moved")
  `DFH_ASSERT(a_byte_idx_bound, (state_r == StAbsorb) |-> (byte_idx_r < nbytes_r), "byte overrun")
  `DFH_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == StIdle && !out_valid), "reset not idle")

endmodule
